>>> design/vsfp_pkg.sv
// Shared types and constants for the vital-sign frame parser.
// Used by vsfp_framer, vsfp_decode and vital_sign_frame_parser; no dependencies.
package vsfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  // control bytes that open a frame
  localparam logic [7:0] CTRL_PULSE  = 8'hF2;
  localparam logic [7:0] CTRL_SPO2   = 8'hF4;
  localparam logic [7:0] CTRL_NIBP   = 8'hF5;
  localparam logic [7:0] CTRL_HEIGHT = 8'hF7;
  localparam logic [7:0] CTRL_WEIGHT = 8'hF8;
  localparam logic [7:0] CTRL_TEMP   = 8'hFA;

  localparam logic [7:0] SPO2_MAX       = 8'd100;
  localparam logic [7:0] PULSE_MIN      = 8'd30;
  localparam logic [7:0] PULSE_MAX      = 8'd239;
  localparam logic [7:0] HEIGHT_INVALID = 8'h80;
  localparam logic [7:0] NIBP_MODE_LIVE  = 8'd1;
  localparam logic [7:0] NIBP_MODE_FINAL = 8'd0;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EVT_SPO2_PULSE = 3'd0,
    EVT_NIBP_LIVE  = 3'd1,
    EVT_NIBP_FINAL = 3'd2,
    EVT_TEMP       = 3'd3,
    EVT_WEIGHT     = 3'd4,
    EVT_HEIGHT     = 3'd5
  } evt_kind_t;

  // one completed frame handed from framer to decoder
  typedef struct packed {
    logic [7:0]      ctrl;
    logic [7:0]      len;
    logic [3:0][7:0] p;
  } frame_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic [6:0]  spo2;
    logic [7:0]  pulse;
    logic [14:0] pressure;
    logic [7:0]  diastolic;
    logic [11:0] temp_tenths;
    logic [7:0]  temp_unit;
    logic [8:0]  weight;
    logic [7:0]  height;
  } result_t;

  function automatic logic is_control(input logic [7:0] b);
    return (b == CTRL_PULSE) || (b == CTRL_SPO2) || (b == CTRL_NIBP) ||
           (b == CTRL_HEIGHT) || (b == CTRL_WEIGHT) || (b == CTRL_TEMP);
  endfunction

endpackage

>>> design/vital_sign_frame_parser.sv
// A result passes through the frame register, then the output register, after
// the last payload byte of its frame. Throughput: one byte per cycle while
// in_stall is low; the frame register and the output register each take a
// new entry in the cycle the previous one moves on.
// Reset: synchronous, active low; returns to hunting for a control byte with
// no SpO2 or pulse reading held.
module vital_sign_frame_parser #(
  parameter int MAX_PAYLOAD = vsfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [6:0]  out_spo2_percent,
  output logic [7:0]  out_pulse_rate,
  output logic [14:0] out_pressure_value,
  output logic [7:0]  out_diastolic_value,
  output logic [11:0] out_temperature_tenths,
  output logic [7:0]  out_temperature_unit,
  output logic [8:0]  out_weight_value,
  output logic [7:0]  out_height_value
);

  logic              in_accept;
  logic              frm_valid;
  logic              frm_take;
  vsfp_pkg::frame_t  frm;
  vsfp_pkg::result_t res;

  // hold bytes only while a finished frame cannot move on
  assign in_stall  = frm_valid && !frm_take;
  assign in_accept = in_valid && !in_stall;

  vsfp_framer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_rx_byte(in_rx_byte),
    .frm_take  (frm_take),
    .frm_valid (frm_valid),
    .frm       (frm)
  );

  vsfp_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .frm_valid(frm_valid),
    .frm      (frm),
    .frm_take (frm_take),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (res)
  );

  assign out_event_kind         = res.kind;
  assign out_spo2_percent       = res.spo2;
  assign out_pulse_rate         = res.pulse;
  assign out_pressure_value     = res.pressure;
  assign out_diastolic_value    = res.diastolic;
  assign out_temperature_tenths = res.temp_tenths;
  assign out_temperature_unit   = res.temp_unit;
  assign out_weight_value       = res.weight;
  assign out_height_value       = res.height;

endmodule

>>> design/vsfp_framer.sv
// Byte-level frame assembly: hunts for a control byte, checks the length,
// collects the payload head and registers each completed frame. Uses vsfp_pkg.
module vsfp_framer #(
  parameter int MAX_PAYLOAD = vsfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic [7:0]      in_rx_byte,
  input  logic            frm_take,
  output logic            frm_valid,
  output vsfp_pkg::frame_t frm
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  vsfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0][7:0]  head_r, head_nxt;
  logic             done;
  logic             frm_valid_r;
  vsfp_pkg::frame_t frm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vsfp_pkg::PH_CTRL;
      ctrl_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      ctrl_r  <= ctrl_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      head_r <= head_nxt;
    end
  end

  always_comb begin
    phase_nxt = vsfp_pkg::PH_CTRL;
    ctrl_nxt  = ctrl_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    done      = 1'b0;
    unique case (phase_r)
      vsfp_pkg::PH_LEN: begin
        len_nxt = in_rx_byte[CNT_W-1:0];
        if (in_rx_byte == 8'd0 || in_rx_byte > 8'(MAX_PAYLOAD)) begin
          phase_nxt = vsfp_pkg::PH_CTRL;
        end else begin
          cnt_nxt   = '0;
          phase_nxt = vsfp_pkg::PH_DATA;
        end
      end
      vsfp_pkg::PH_DATA: begin
        // keep only the first four payload bytes
        if (cnt_r < CNT_W'(4)) begin
          head_nxt[cnt_r[1:0]] = in_rx_byte;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt >= len_r) begin
          phase_nxt = vsfp_pkg::PH_CTRL;
          done      = 1'b1;
        end else begin
          phase_nxt = vsfp_pkg::PH_DATA;
        end
      end
      default: begin
        if (vsfp_pkg::is_control(in_rx_byte)) begin
          ctrl_nxt  = in_rx_byte;
          phase_nxt = vsfp_pkg::PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_valid_r <= 1'b0;
    end else if (in_accept && done) begin
      frm_valid_r <= 1'b1;
    end else if (frm_take) begin
      frm_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && done) begin
      frm_r.ctrl <= ctrl_r;
      frm_r.len  <= 8'(len_r);
      frm_r.p    <= head_nxt;
    end
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == vsfp_pkg::PH_DATA |-> cnt_r < len_r)
    else $error("payload count reached frame length while collecting");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == vsfp_pkg::PH_DATA |-> len_r != '0)
    else $error("collecting payload of zero length");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && frm_valid_r && !frm_take))
    else $error("byte taken while frame register full");

endmodule

>>> design/vsfp_decode.sv
// Frame decoder: turns a completed frame into an event, pairs SpO2 with
// pulse, and holds the result in the output register. Uses vsfp_pkg.
module vsfp_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             frm_valid,
  input  vsfp_pkg::frame_t frm,
  output logic             frm_take,
  input  logic             out_stall,
  output logic             out_valid,
  output vsfp_pkg::result_t out_res
);

  logic              out_valid_r;
  vsfp_pkg::result_t out_r;
  vsfp_pkg::result_t res;
  logic              has_res;
  logic              pair_chk;
  logic [6:0]        held_spo2_r, held_spo2_nxt;
  logic [7:0]        held_pulse_r, held_pulse_nxt;
  logic              spo2_present_r, spo2_present_nxt;
  logic              pulse_present_r, pulse_present_nxt;
  logic [14:0]       packed_p;
  logic              pair_done;

  assign frm_take = frm_valid && (!out_valid_r || !out_stall);
  assign packed_p = {frm.p[1], 7'b0} | 15'(frm.p[2]);

  always_comb begin
    res               = '0;
    has_res           = 1'b0;
    pair_chk          = 1'b0;
    pair_done         = 1'b0;
    held_spo2_nxt     = held_spo2_r;
    held_pulse_nxt    = held_pulse_r;
    spo2_present_nxt  = spo2_present_r;
    pulse_present_nxt = pulse_present_r;
    unique case (frm.ctrl)
      vsfp_pkg::CTRL_SPO2: begin
        if (frm.len == 8'd1) begin
          held_spo2_nxt    = (frm.p[0] > vsfp_pkg::SPO2_MAX) ? 7'd0 : frm.p[0][6:0];
          spo2_present_nxt = 1'b1;
          pair_chk         = 1'b1;
        end
      end
      vsfp_pkg::CTRL_PULSE: begin
        if (frm.len == 8'd1) begin
          held_pulse_nxt    = (frm.p[0] < vsfp_pkg::PULSE_MIN ||
                               frm.p[0] > vsfp_pkg::PULSE_MAX) ? 8'd0 : frm.p[0];
          pulse_present_nxt = 1'b1;
          pair_chk          = 1'b1;
        end
      end
      vsfp_pkg::CTRL_NIBP: begin
        if (frm.p[0] == vsfp_pkg::NIBP_MODE_LIVE) begin
          if (frm.len >= 8'd3) begin
            has_res      = 1'b1;
            res.kind     = vsfp_pkg::EVT_NIBP_LIVE;
            res.pressure = packed_p;
          end
        end else if (frm.p[0] == vsfp_pkg::NIBP_MODE_FINAL) begin
          if ((frm.len == 8'd4 || frm.len == 8'd6) &&
              !(packed_p == 15'd0 && frm.p[3] == 8'd0)) begin
            has_res       = 1'b1;
            res.kind      = vsfp_pkg::EVT_NIBP_FINAL;
            res.pressure  = packed_p;
            res.diastolic = frm.p[3];
          end
        end
      end
      vsfp_pkg::CTRL_TEMP: begin
        if (frm.len == 8'd3) begin
          has_res         = 1'b1;
          res.kind        = vsfp_pkg::EVT_TEMP;
          // times ten as times eight plus times two
          res.temp_tenths = 12'({frm.p[0], 3'b0}) + 12'({frm.p[0], 1'b0}) +
                            12'(frm.p[1]);
          res.temp_unit   = frm.p[2];
        end
      end
      vsfp_pkg::CTRL_WEIGHT: begin
        if (frm.len >= 8'd2) begin
          has_res    = 1'b1;
          res.kind   = vsfp_pkg::EVT_WEIGHT;
          res.weight = 9'(frm.p[0]) + 9'(frm.p[1]);
        end
      end
      vsfp_pkg::CTRL_HEIGHT: begin
        if (frm.len >= 8'd2 && frm.p[1] != vsfp_pkg::HEIGHT_INVALID) begin
          has_res    = 1'b1;
          res.kind   = vsfp_pkg::EVT_HEIGHT;
          res.height = frm.p[1];
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
    // emit the pair once both readings are held, then drop them
    if (pair_chk && spo2_present_nxt && pulse_present_nxt) begin
      pair_done         = 1'b1;
      has_res           = 1'b1;
      res.kind          = vsfp_pkg::EVT_SPO2_PULSE;
      res.spo2          = held_spo2_nxt;
      res.pulse         = held_pulse_nxt;
      held_spo2_nxt     = '0;
      held_pulse_nxt    = '0;
      spo2_present_nxt  = 1'b0;
      pulse_present_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_spo2_r     <= '0;
      held_pulse_r    <= '0;
      spo2_present_r  <= 1'b0;
      pulse_present_r <= 1'b0;
    end else if (frm_take) begin
      held_spo2_r     <= held_spo2_nxt;
      held_pulse_r    <= held_pulse_nxt;
      spo2_present_r  <= spo2_present_nxt;
      pulse_present_r <= pulse_present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frm_take) begin
      out_valid_r <= has_res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_take && has_res) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frm_take && pair_done |=> !spo2_present_r && !pulse_present_r)
    else $error("held readings not cleared after pair");

  a_never_both_held: assert property (@(posedge clk) disable iff (!rst_n)
    !(spo2_present_r && pulse_present_r))
    else $error("both readings held without a pair result");

  a_spo2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == vsfp_pkg::EVT_SPO2_PULSE |-> out_r.spo2 <= 7'd100)
    else $error("SpO2 result above 100");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == vsfp_pkg::EVT_SPO2_PULSE |->
      out_r.pulse == 8'd0 || (out_r.pulse >= 8'd30 && out_r.pulse <= 8'd239))
    else $error("pulse result outside range");

endmodule
